// ----- hdl/rsw_pkg.sv -----
// Package for the range-sum window counter.
// Sizes, register indexes and controller/datapath handshake structs.
// No dependencies.
`timescale 1ns / 1ps

package rsw_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int PREFIX_W    = 48;
    localparam int DIFF_W      = PREFIX_W + 1;
    localparam int SAMPLE_W    = 32;
    localparam int MATCH_W     = 10;
    localparam int TOTAL_W     = 19;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = CFG_IDX_W'(1);

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic pipe_busy;
        logic full;
        logic out_free;
    } dp_sts_t;

endpackage

// ----- hdl/rsw_in_if.sv -----
// Input channel: one sample transaction with valid/ready.
// Depends on rsw_pkg.
`timescale 1ns / 1ps

interface rsw_in_if;
    import rsw_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                first;

    modport source (output valid, output sample, output first, input ready);
    modport sink   (input valid, input sample, input first, output ready);
endinterface

// ----- hdl/rsw_out_if.sv -----
// Output channel: one result transaction with valid/ready.
// Depends on rsw_pkg.
`timescale 1ns / 1ps

interface rsw_out_if;
    import rsw_pkg::*;

    logic               valid;
    logic               ready;
    logic [MATCH_W-1:0] matches_here;
    logic [TOTAL_W-1:0] total_matches;
    logic               store_full;

    modport source (output valid, output matches_here, output total_matches,
                    output store_full, input ready);
    modport sink   (input valid, input matches_here, input total_matches,
                    input store_full, output ready);
endinterface

// ----- hdl/rsw_ctrl.sv -----
// Controller FSM: sequences load, store scan, drain and result write-back.
// Depends on rsw_pkg.
`timescale 1ns / 1ps

module rsw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rsw_pkg::dp_sts_t sts,
    output rsw_pkg::dp_cmd_t cmd
);
    import rsw_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        DRAIN,
        FINISH
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    assign in_ready   = ready_reg;
    assign cmd.load   = in_valid && ready_reg;
    assign cmd.scan   = (state_reg == SCAN) && !sts.full && !sts.scan_done;
    assign cmd.finish = (state_reg == FINISH) && sts.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                    if (in_valid && ready_reg)
                    begin
                        state_reg <= SCAN;
                        ready_reg <= 1'b0;
                    end
                end
                SCAN:
                begin
                    if (sts.full)
                    begin
                        state_reg <= FINISH;
                    end
                    else if (sts.scan_done)
                    begin
                        state_reg <= DRAIN;
                    end
                end
                DRAIN:
                begin
                    if (!sts.pipe_busy)
                    begin
                        state_reg <= FINISH;
                    end
                end
                FINISH:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    // one transaction in flight at a time
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !ready_reg)
        else $error("rsw_ctrl: accepted while busy");

    // results only written once the compare pipeline is empty
    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && !sts.full) |-> !sts.pipe_busy)
        else $error("rsw_ctrl: finish with pipeline busy");

endmodule

// ----- hdl/rsw_dp.sv -----
// Datapath: config registers, prefix store memory, compare pipeline,
// counters and the output register. Depends on rsw_pkg and rsw_out_if.
`timescale 1ns / 1ps

module rsw_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rsw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rsw_pkg::PREFIX_W-1:0]  cfg_data,
    input  logic [rsw_pkg::SAMPLE_W-1:0]  sample,
    input  logic                          first,
    input  rsw_pkg::dp_cmd_t              cmd,
    output rsw_pkg::dp_sts_t              sts,
    rsw_out_if.source                     results
);
    import rsw_pkg::*;

    logic [PREFIX_W-1:0] mem [STORE_DEPTH];

    logic [PREFIX_W-1:0] range_low_reg;
    logic [PREFIX_W-1:0] range_high_reg;
    logic [PREFIX_W-1:0] prefix_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic                full_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [ADDR_W-1:0]   hits_reg;
    logic [PREFIX_W-1:0] rdata_reg;
    logic                vld1_reg;
    logic [DIFF_W-1:0]   diff_reg;
    logic                vld2_reg;

    logic                out_valid_reg;
    logic [MATCH_W-1:0]  out_match_reg;
    logic [TOTAL_W-1:0]  out_total_reg;
    logic                out_full_reg;

    logic [CNT_W-1:0]    eff_count;
    logic [PREFIX_W-1:0] eff_prefix;
    logic [TOTAL_W-1:0]  eff_total;
    logic [TOTAL_W-1:0]  total_next;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [PREFIX_W-1:0] mem_wdata;
    logic [DIFF_W-1:0]   diff_next;
    logic                in_window;

    assign eff_count  = first ? CNT_W'(1) : count_reg;
    assign eff_prefix = first ? '0 : prefix_reg;
    assign eff_total  = first ? '0 : total_reg;
    assign total_next = total_reg + TOTAL_W'(hits_reg);

    assign mem_we    = (cmd.load && first) || (cmd.finish && !full_reg);
    assign mem_waddr = cmd.load ? '0 : count_reg[ADDR_W-1:0];
    assign mem_wdata = cmd.load ? '0 : prefix_reg;

    assign diff_next = {prefix_reg[PREFIX_W-1], prefix_reg}
                     - {rdata_reg[PREFIX_W-1], rdata_reg};
    assign in_window =
        ($signed(diff_reg) >= $signed({range_low_reg[PREFIX_W-1], range_low_reg})) &&
        ($signed(diff_reg) <= $signed({range_high_reg[PREFIX_W-1], range_high_reg}));

    assign sts.scan_done = (idx_reg == count_reg);
    assign sts.pipe_busy = vld1_reg || vld2_reg;
    assign sts.full      = full_reg;
    assign sts.out_free  = !out_valid_reg || results.ready;

    assign results.valid         = out_valid_reg;
    assign results.matches_here  = out_match_reg;
    assign results.total_matches = out_total_reg;
    assign results.store_full    = out_full_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.scan)
        begin
            rdata_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '0;
            range_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RANGE_LOW:  range_low_reg  <= cfg_data;
                REG_RANGE_HIGH: range_high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg    <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            full_reg      <= 1'b0;
            idx_reg       <= '0;
            hits_reg      <= '0;
            vld1_reg      <= 1'b0;
            vld2_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_match_reg <= '0;
            out_total_reg <= '0;
            out_full_reg  <= 1'b0;
        end
        else
        begin
            vld1_reg <= cmd.scan;
            vld2_reg <= vld1_reg;

            if (cmd.load)
            begin
                count_reg <= eff_count;
                total_reg <= eff_total;
                full_reg  <= (eff_count == CNT_W'(STORE_DEPTH));
                if (eff_count != CNT_W'(STORE_DEPTH))
                begin
                    prefix_reg <= eff_prefix + {{(PREFIX_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
                end
                idx_reg  <= '0;
                hits_reg <= '0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                if (vld2_reg && in_window)
                begin
                    hits_reg <= hits_reg + ADDR_W'(1);
                end
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (full_reg)
                begin
                    out_match_reg <= '0;
                    out_total_reg <= total_reg;
                    out_full_reg  <= 1'b1;
                end
                else
                begin
                    count_reg     <= count_reg + CNT_W'(1);
                    total_reg     <= total_next;
                    out_match_reg <= MATCH_W'(hits_reg);
                    out_total_reg <= total_next;
                    out_full_reg  <= 1'b0;
                end
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STORE_DEPTH))
        else $error("rsw_dp: entry count beyond store depth");

    a_hits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(hits_reg) <= idx_reg)
        else $error("rsw_dp: more hits than entries scanned");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && !full_reg) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("rsw_dp: entry count not advanced on write-back");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && full_reg) |=> total_reg == $past(total_reg))
        else $error("rsw_dp: total changed for an ignored sample");

endmodule

// ----- hdl/range_sum_window_counter.sv -----
// Range-sum window counter: counts contiguous runs of a sample stream whose
// sum lies in [range_low, range_high].
//
// Channels: "samples" (sink) carries sample and first; "results" (source)
// carries matches_here, total_matches and store_full. A transaction moves
// on a rising clk edge with valid and ready both high. Config writes use
// cfg_we / cfg_index / cfg_data: index 0 is range_low, index 1 range_high.
// The user must write them only while idle; the block does not enforce it.
// One sample is processed at a time. The stored prefix sums are scanned one
// memory entry per cycle through a three-stage read/subtract/compare pipe,
// so the time from acceptance to result grows with the number of stored
// entries, as the single read port reads one entry at a time.
// The next sample is accepted from the cycle after the previous result is written.
// A sample arriving with a full store skips the scan and is flagged.
// The result sits in an output register; the next sample can be accepted
// while it waits, but its own result waits until the register is free.
// Reset clears the ranges, count, prefix and total; no sequence is open
// until a sample with first set arrives. The store needs no clearing pass.
// Depends on rsw_pkg, rsw_in_if, rsw_out_if, rsw_ctrl, rsw_dp.
`timescale 1ns / 1ps

module range_sum_window_counter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rsw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rsw_pkg::PREFIX_W-1:0]  cfg_data,
    rsw_in_if.sink                        samples,
    rsw_out_if.source                     results
);
    import rsw_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    ready;

    assign samples.ready = ready;

    rsw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rsw_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (samples.sample),
        .first     (samples.first),
        .cmd       (cmd),
        .sts       (sts),
        .results   (results)
    );

endmodule
